// File: sv/scope_trigger_sweep_core_macros.svh
// Assertion macros used by the sweep core back end.
// Needs signals named clock and reset in the module that uses them.
`ifndef SCOPE_TRIGGER_SWEEP_CORE_MACROS_SVH
`define SCOPE_TRIGGER_SWEEP_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define STSW_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sweep core check failed");

// condition must never be seen outside reset
`define STSW_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("sweep core forbidden condition");

`endif

// File: sv/stsw_pkg.sv
// Shared types and constants of the scope trigger sweep core.
// No dependencies.
`timescale 1ns / 1ps

package stsw_pkg;

   // sweep phase, one-hot
   typedef enum logic [3:0] {
      PH_HELD  = 4'b0001,
      PH_ARMED = 4'b0010,
      PH_TRIG  = 4'b0100,
      PH_RUN   = 4'b1000
   } phase_type;

   // back-end sequencer, one-hot
   typedef enum logic [5:0] {
      SQ_IDLE = 6'b000001,
      SQ_EVAL = 6'b000010,
      SQ_MUL  = 6'b000100,
      SQ_FRAC = 6'b001000,
      SQ_POS  = 6'b010000,
      SQ_SEND = 6'b100000
   } seq_type;

   localparam logic [1:0] SLOPE_FREE = 2'd0;
   localparam logic [1:0] SLOPE_RISE = 2'd1;
   localparam logic [1:0] SLOPE_FALL = 2'd2;

   localparam logic [2:0] REG_PERIOD  = 3'd0;
   localparam logic [2:0] REG_LEVEL   = 3'd1;
   localparam logic [2:0] REG_SLOPE   = 3'd2;
   localparam logic [2:0] REG_HOLDOFF = 3'd3;
   localparam logic [2:0] REG_DELAY   = 3'd4;

   localparam logic signed [17:0] Q_HALF = 18'sd32768;
   localparam logic signed [17:0] Q_ONE  = 18'sd65536;
   localparam int POS_FRAC_BITS = 16;

endpackage

// File: sv/stsw_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Uses no package items.
`timescale 1ns / 1ps

module stsw_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [31:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [31:0]   dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [32:0]   cand, diff;
   logic          ge;

   always_comb begin
      cand   = {rem_ff, quo_ff[DW-1]};
      diff   = cand - {1'b0, dvs_ff};
      ge     = (cand >= {1'b0, dvs_ff});
      rem_in = ge ? diff[31:0] : cand[31:0];
      quo_in = {quo_ff[DW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/stsw_front.sv
// Front end: takes sample words and holds them in a two-entry queue.
// Uses no package items.
`timescale 1ns / 1ps

module stsw_front #(
   parameter int WW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [WW-1:0] in_word,
   output logic          q_valid,
   input  logic          q_pop,
   output logic [WW-1:0] q_word
);
   logic [WW-1:0] mem_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    cnt_ff;
   logic          push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;
   assign q_word   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
   end

endmodule

// File: sv/stsw_back.sv
// Back end: sweep phase machine, interpolation and position math.
// Depends on stsw_pkg, stsw_div and the assertion macro header.
`timescale 1ns / 1ps
`include "scope_trigger_sweep_core_macros.svh"

module stsw_back #(
   parameter int TW = 48,
   parameter int SB = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   cfg_period,
   input  logic [15:0]   cfg_level,
   input  logic [1:0]    cfg_slope,
   input  logic [31:0]   cfg_holdoff,
   input  logic [31:0]   cfg_delay,
   input  logic          q_valid,
   output logic          q_pop,
   input  logic [TW-1:0] q_time,
   input  logic [SB-1:0] q_value,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [TW-1:0] out_time,
   output logic [17:0]   out_pos,
   output logic          out_lift,
   output logic          out_last
);
   localparam int NW = (SB > 16) ? SB : 16;
   localparam int DW = TW + NW;
   localparam int MW = $clog2(SB + 1);

   stsw_pkg::seq_type   sq_ff;
   stsw_pkg::phase_type phase_ff;
   logic                started_ff, prvv_ff, pov_ff, hs_ff, pend_ff;
   logic [TW-1:0]       start_ff, pt_ff, hoe_ff, cur_t_ff, dt_ff;
   logic signed [SB-1:0] prv_ff, cur_y_ff, lvl;
   logic signed [17:0]  pop_ff, out_pos_ff, pos;
   logic [SB-1:0]       num_ff, den_ff, num_in, den_in;
   logic [DW-1:0]       prod_ff, div_q, div_dvd;
   logic [MW-1:0]       mcnt_ff;
   logic                out_lift_ff, out_last_ff;
   logic [TW-1:0]       delay_t, hold_t, tdiff;
   logic [31:0]         per, div_dvs;
   logic                rise, fall, hit, div_start, div_busy, div_done;
   logic signed [SB:0]  d_lp, d_pl, d_yp, d_py;

   assign lvl     = SB'({16'b0, cfg_level});
   assign delay_t = TW'(cfg_delay);
   assign hold_t  = TW'(cfg_holdoff);
   assign per     = (cfg_period == 32'd0) ? 32'd1 : cfg_period;
   assign tdiff   = cur_t_ff - start_ff;

   always_comb begin
      d_lp = {lvl[SB-1], lvl} - {prv_ff[SB-1], prv_ff};
      d_pl = {prv_ff[SB-1], prv_ff} - {lvl[SB-1], lvl};
      d_yp = {cur_y_ff[SB-1], cur_y_ff} - {prv_ff[SB-1], prv_ff};
      d_py = {prv_ff[SB-1], prv_ff} - {cur_y_ff[SB-1], cur_y_ff};
      rise = prvv_ff && (prv_ff <= lvl) && (lvl <= cur_y_ff) && (prv_ff < cur_y_ff);
      fall = prvv_ff && (prv_ff >= lvl) && (lvl >= cur_y_ff) && (prv_ff > cur_y_ff);
      hit  = (cfg_slope == stsw_pkg::SLOPE_RISE) ? rise : fall;
      num_in = (cfg_slope == stsw_pkg::SLOPE_RISE) ? d_lp[SB-1:0] : d_pl[SB-1:0];
      den_in = (cfg_slope == stsw_pkg::SLOPE_RISE) ? d_yp[SB-1:0] : d_py[SB-1:0];
   end

   // one divider serves the crossing interpolation and the sweep position
   assign div_start = ((sq_ff == stsw_pkg::SQ_MUL) && (mcnt_ff == '0)) ||
                      ((sq_ff == stsw_pkg::SQ_EVAL) && (phase_ff == stsw_pkg::PH_RUN));
   assign div_dvd   = (sq_ff == stsw_pkg::SQ_MUL) ? prod_ff : DW'({tdiff, 16'b0});
   assign div_dvs   = (sq_ff == stsw_pkg::SQ_MUL) ? 32'(den_ff) : per;

   stsw_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign pos = $signed({2'b00, div_q[stsw_pkg::POS_FRAC_BITS-1:0]}) - stsw_pkg::Q_HALF;
   assign q_pop = (sq_ff == stsw_pkg::SQ_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff      <= stsw_pkg::SQ_IDLE;
         phase_ff   <= stsw_pkg::PH_HELD;
         started_ff <= 1'b0;
         start_ff   <= '0;
         pt_ff      <= '0;
         hoe_ff     <= '0;
         prv_ff     <= '0;
         prvv_ff    <= 1'b0;
         pop_ff     <= '0;
         pov_ff     <= 1'b0;
         hs_ff      <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         unique case (sq_ff)
            stsw_pkg::SQ_IDLE: begin
               if (q_valid) begin
                  cur_t_ff <= q_time;
                  cur_y_ff <= q_value;
                  if (!started_ff) begin
                     started_ff <= 1'b1;
                     start_ff   <= q_time;
                     hoe_ff     <= q_time + hold_t;
                     pt_ff      <= q_time;
                  end
                  sq_ff <= stsw_pkg::SQ_EVAL;
               end
            end
            stsw_pkg::SQ_EVAL: begin
               out_pos_ff  <= '0;
               out_lift_ff <= 1'b1;
               out_last_ff <= 1'b1;
               pend_ff     <= 1'b0;
               unique case (phase_ff)
                  stsw_pkg::PH_HELD: begin
                     if (cur_t_ff >= hoe_ff) begin
                        phase_ff <= stsw_pkg::PH_ARMED;
                        start_ff <= hoe_ff;
                        prvv_ff  <= 1'b0;
                     end else begin
                        pt_ff <= cur_t_ff;
                        hs_ff <= 1'b1;
                        sq_ff <= stsw_pkg::SQ_SEND;
                     end
                  end
                  stsw_pkg::PH_ARMED: begin
                     if (cfg_slope == stsw_pkg::SLOPE_RISE ||
                         cfg_slope == stsw_pkg::SLOPE_FALL) begin
                        if (hit) begin
                           num_ff  <= num_in;
                           den_ff  <= den_in;
                           dt_ff   <= cur_t_ff - pt_ff;
                           prod_ff <= '0;
                           mcnt_ff <= MW'(SB);
                           sq_ff   <= stsw_pkg::SQ_MUL;
                        end else begin
                           prv_ff  <= cur_y_ff;
                           prvv_ff <= 1'b1;
                           pt_ff   <= cur_t_ff;
                           sq_ff   <= stsw_pkg::SQ_SEND;
                        end
                     end else begin
                        phase_ff <= stsw_pkg::PH_TRIG;
                        if (hs_ff) begin
                           start_ff <= cur_t_ff + delay_t;
                           hs_ff    <= 1'b0;
                        end
                        pov_ff <= 1'b0;
                     end
                  end
                  stsw_pkg::PH_TRIG: begin
                     if (cfg_delay == 32'd0 || cur_t_ff >= start_ff) begin
                        phase_ff <= stsw_pkg::PH_RUN;
                     end else begin
                        pt_ff <= cur_t_ff;
                        sq_ff <= stsw_pkg::SQ_SEND;
                     end
                  end
                  stsw_pkg::PH_RUN: begin
                     sq_ff <= stsw_pkg::SQ_POS;
                  end
                  default: ;
               endcase
            end
            stsw_pkg::SQ_MUL: begin
               // shift-add product dt * num, numerator bits from the top
               if (mcnt_ff != '0) begin
                  prod_ff <= (prod_ff << 1) + (num_ff[SB-1] ? DW'(dt_ff) : '0);
                  num_ff  <= num_ff << 1;
                  mcnt_ff <= mcnt_ff - 1'b1;
               end else begin
                  sq_ff <= stsw_pkg::SQ_FRAC;
               end
            end
            stsw_pkg::SQ_FRAC: begin
               if (div_done) begin
                  start_ff <= pt_ff + div_q[TW-1:0] + delay_t;
                  phase_ff <= stsw_pkg::PH_TRIG;
                  hs_ff    <= 1'b0;
                  pov_ff   <= 1'b0;
                  sq_ff    <= stsw_pkg::SQ_EVAL;
               end
            end
            stsw_pkg::SQ_POS: begin
               if (div_done) begin
                  sq_ff <= stsw_pkg::SQ_SEND;
                  if (pov_ff && (pos < pop_ff)) begin
                     // wrap: closing point past the right edge, then pen lift
                     phase_ff    <= stsw_pkg::PH_HELD;
                     hoe_ff      <= cur_t_ff + hold_t;
                     pov_ff      <= 1'b0;
                     out_pos_ff  <= pos + stsw_pkg::Q_ONE;
                     out_lift_ff <= 1'b0;
                     out_last_ff <= 1'b0;
                     pend_ff     <= 1'b1;
                  end else begin
                     pop_ff      <= pos;
                     pov_ff      <= 1'b1;
                     pt_ff       <= cur_t_ff;
                     out_pos_ff  <= pos;
                     out_lift_ff <= 1'b0;
                     out_last_ff <= 1'b1;
                  end
               end
            end
            stsw_pkg::SQ_SEND: begin
               if (out_ready) begin
                  if (pend_ff) begin
                     out_pos_ff  <= '0;
                     out_lift_ff <= 1'b1;
                     out_last_ff <= 1'b1;
                     pend_ff     <= 1'b0;
                  end else begin
                     sq_ff <= stsw_pkg::SQ_IDLE;
                  end
               end
            end
            default: sq_ff <= stsw_pkg::SQ_IDLE;
         endcase
      end
   end

   assign out_valid = (sq_ff == stsw_pkg::SQ_SEND);
   assign out_time  = cur_t_ff;
   assign out_pos   = out_pos_ff;
   assign out_lift  = out_lift_ff;
   assign out_last  = out_last_ff;

   `STSW_NEVER(a_div_restart, div_start && div_busy)
   `STSW_CHECK(a_wrap_point_drawn, (out_valid && !out_last) |-> !out_lift)
   `STSW_CHECK(a_pend_only_send, pend_ff |-> (out_valid && !out_last))
   `STSW_CHECK(a_wrap_to_held, (out_valid && !out_last) |-> (phase_ff == stsw_pkg::PH_HELD))

endmodule

// File: sv/scope_trigger_sweep_core.sv
// Path of a sample word: a pen-lift word goes from evaluation to the output; a run word
//   also takes a pass through the shared divider for its sweep position;
//   a trigger adds a shift-add multiply and a divider pass for the interpolation.
// Throughput: one sample word at a time through the back end; the divider and rsp_tready back-pressure set the rate.
// Reset: synchronous, active high; phase held, config and control registers to their defaults.
`timescale 1ns / 1ps

module scope_trigger_sweep_core #(
   parameter int TIME_BITS   = 48,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // sample stream
   input  logic req_tvalid,
   output logic req_tready,
   // sample_time, sample_value
   input  logic [((TIME_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // frame stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // frame_time, sweep_pos
   output logic [((TIME_BITS+18+7)/8)*8-1:0] rsp_tdata,
   // pen_lift
   output logic rsp_tuser,
   output logic rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int WW = TIME_BITS + SAMPLE_BITS;
   localparam int OW = ((TIME_BITS + 18 + 7) / 8) * 8;

   logic [31:0] period_ff, holdoff_ff, delay_ff;
   logic [15:0] level_ff;
   logic [1:0]  slope_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   logic          q_valid, q_pop;
   logic [WW-1:0] q_word;
   logic [TIME_BITS-1:0] o_time;
   logic [17:0]   o_pos;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= 32'd1000;
         level_ff   <= 16'd0;
         slope_ff   <= stsw_pkg::SLOPE_RISE;
         holdoff_ff <= 32'd0;
         delay_ff   <= 32'd0;
      end else if (wr_en) begin
         unique case (reg_idx)
            stsw_pkg::REG_PERIOD:  period_ff  <= csr_pwdata;
            stsw_pkg::REG_LEVEL:   level_ff   <= csr_pwdata[15:0];
            stsw_pkg::REG_SLOPE:   slope_ff   <= csr_pwdata[1:0];
            stsw_pkg::REG_HOLDOFF: holdoff_ff <= csr_pwdata;
            stsw_pkg::REG_DELAY:   delay_ff   <= csr_pwdata;
            default: ;  // unmapped addresses drop the write
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         stsw_pkg::REG_PERIOD:  csr_prdata = period_ff;
         stsw_pkg::REG_LEVEL:   csr_prdata = {16'd0, level_ff};
         stsw_pkg::REG_SLOPE:   csr_prdata = {30'd0, slope_ff};
         stsw_pkg::REG_HOLDOFF: csr_prdata = holdoff_ff;
         stsw_pkg::REG_DELAY:   csr_prdata = delay_ff;
         default:               csr_prdata = 32'd0;
      endcase
   end

   // front: sample words queue up here while the back end works
   stsw_front #(.WW(WW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (req_tdata[WW-1:0]),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_word   (q_word)
   );

   // back: phase machine, trigger interpolation, sweep position
   stsw_back #(.TW(TIME_BITS), .SB(SAMPLE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_period  (period_ff),
      .cfg_level   (level_ff),
      .cfg_slope   (slope_ff),
      .cfg_holdoff (holdoff_ff),
      .cfg_delay   (delay_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_time      (q_word[TIME_BITS-1:0]),
      .q_value     (q_word[WW-1:TIME_BITS]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_time    (o_time),
      .out_pos     (o_pos),
      .out_lift    (rsp_tuser),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = OW'({o_pos, o_time});

endmodule
